FILE: design/spgm_pkg.sv
// shared types, constants and helper functions of the saturation peak marker
package spgm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_W    = 11;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd64;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd64;

  localparam logic [3:0] NB_CENTRE = 4'd0;
  localparam logic [3:0] NB_LAST   = 4'd8;
  localparam logic [2:0] TAP_LAST  = 3'd4;
  localparam logic [2:0] DIV_LAST  = 3'd7;
  localparam logic [1:0] CAND_LAST = 2'd3;

  localparam logic [5:0] GAUSS_W [0:4][0:4] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  typedef struct packed {
    logic       accept;
    logic       prep;
    logic       sat_wr;
    logic [1:0] cand;
    logic [3:0] nb;
    logic       nb_rd;
    logic       nb_cmp;
    logic       pk_wr;
    logic       advance;
    logic [2:0] tap_y;
    logic [2:0] tap_x;
    logic       tap_rd;
    logic       tap_acc;
    logic       div_init;
    logic       div_step;
    logic       emit;
  } spgm_cmd_t;

  typedef struct packed {
    logic pixel;
    logic cand_ok;
    logic nb_in;
    logic tap_in;
    logic out_ready;
    logic out_free;
  } spgm_sts_t;

  function automatic logic [5:0] gauss_w(logic [2:0] ty, logic [2:0] tx);
    return GAUSS_W[ty][tx];
  endfunction

  // row offset of a 3x3 neighbour
  function automatic logic signed [2:0] nb_dy(logic [3:0] j);
    logic signed [2:0] d;
    unique case (j)
      4'd1, 4'd2, 4'd3: d = -3'sd1;
      4'd6, 4'd7, 4'd8: d = 3'sd1;
      default:          d = 3'sd0;
    endcase
    return d;
  endfunction

  // column offset of a 3x3 neighbour
  function automatic logic signed [2:0] nb_dx(logic [3:0] j);
    logic signed [2:0] d;
    unique case (j)
      4'd1, 4'd4, 4'd6: d = -3'sd1;
      4'd3, 4'd5, 4'd8: d = 3'sd1;
      default:          d = 3'sd0;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] mod3_dec(logic [1:0] v);
    return (v == 2'd0) ? 2'd2 : v - 2'd1;
  endfunction

  function automatic logic [1:0] mod3_inc(logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

endpackage

FILE: design/spgm_ram.sv
// generic simple dual port ram with registered read
module spgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: design/spgm_ctrl.sv
// sequencing state machine of the saturation peak marker
module spgm_ctrl import spgm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  spgm_sts_t sts_i,
  output spgm_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SATWR, S_CAND, S_NRD, S_NCMP, S_PKWR,
    S_ADV, S_CHK, S_ERD, S_EACC, S_DIVI, S_DIVS, S_OUTW
  } state_e;

  state_e     state_q;
  logic [1:0] k_q;
  logic [3:0] j_q;
  logic [2:0] ty_q, tx_q, ds_q;
  logic       tap_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign tap_last   = (ty_q == TAP_LAST) && (tx_q == TAP_LAST);

  always_comb begin
    cmd_o       = '0;
    cmd_o.cand  = k_q;
    cmd_o.nb    = j_q;
    cmd_o.tap_y = ty_q;
    cmd_o.tap_x = tx_q;
    unique case (state_q)
      S_IDLE:  cmd_o.accept   = in_valid_i;
      S_PREP:  cmd_o.prep     = 1'b1;
      S_SATWR: cmd_o.sat_wr   = 1'b1;
      S_NRD:   cmd_o.nb_rd    = sts_i.nb_in;
      S_NCMP:  cmd_o.nb_cmp   = 1'b1;
      S_PKWR:  cmd_o.pk_wr    = 1'b1;
      S_ADV:   cmd_o.advance  = 1'b1;
      S_ERD:   cmd_o.tap_rd   = sts_i.tap_in;
      S_EACC:  cmd_o.tap_acc  = 1'b1;
      S_DIVI:  cmd_o.div_init = 1'b1;
      S_DIVS:  cmd_o.div_step = 1'b1;
      S_OUTW:  cmd_o.emit     = sts_i.out_free;
      default: cmd_o.emit     = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      j_q     <= '0;
      ty_q    <= '0;
      tx_q    <= '0;
      ds_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_PREP;
        end
        S_PREP: begin
          state_q <= sts_i.pixel ? S_SATWR : S_CHK;
        end
        S_SATWR: begin
          k_q     <= '0;
          state_q <= S_CAND;
        end
        S_CAND: begin
          if (sts_i.cand_ok) begin
            j_q     <= NB_CENTRE;
            state_q <= S_NRD;
          end else if (k_q == CAND_LAST) begin
            state_q <= S_ADV;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        S_NRD: begin
          if (sts_i.nb_in) begin
            state_q <= S_NCMP;
          end else if (j_q == NB_LAST) begin
            state_q <= S_PKWR;
          end else begin
            j_q <= j_q + 4'd1;
          end
        end
        S_NCMP: begin
          if (j_q == NB_LAST) begin
            state_q <= S_PKWR;
          end else begin
            j_q     <= j_q + 4'd1;
            state_q <= S_NRD;
          end
        end
        S_PKWR: begin
          if (k_q == CAND_LAST) begin
            state_q <= S_ADV;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_CAND;
          end
        end
        S_ADV: begin
          state_q <= S_CHK;
        end
        S_CHK: begin
          ty_q    <= '0;
          tx_q    <= '0;
          state_q <= sts_i.out_ready ? S_ERD : S_IDLE;
        end
        S_ERD: begin
          if (sts_i.tap_in) begin
            state_q <= S_EACC;
          end else if (tap_last) begin
            state_q <= S_DIVI;
          end else if (tx_q == TAP_LAST) begin
            tx_q <= '0;
            ty_q <= ty_q + 3'd1;
          end else begin
            tx_q <= tx_q + 3'd1;
          end
        end
        S_EACC: begin
          if (tap_last) begin
            state_q <= S_DIVI;
          end else begin
            state_q <= S_ERD;
            if (tx_q == TAP_LAST) begin
              tx_q <= '0;
              ty_q <= ty_q + 3'd1;
            end else begin
              tx_q <= tx_q + 3'd1;
            end
          end
        end
        S_DIVI: begin
          ds_q    <= '0;
          state_q <= S_DIVS;
        end
        S_DIVS: begin
          if (ds_q == DIV_LAST) begin
            state_q <= S_OUTW;
          end else begin
            ds_q <= ds_q + 3'd1;
          end
        end
        S_OUTW: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/spgm_datapath.sv
// counters, line stores, peak test, window sum and divider of the peak marker
module spgm_datapath import spgm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              opcode_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        gray_o,
  output logic [9:0]        out_x_o,
  output logic [9:0]        out_y_o,
  output logic              frame_end_o,
  input  spgm_cmd_t         cmd_i,
  output spgm_sts_t         sts_o
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int SW  = ((CW > RW) ? CW : RW) + 2;
  localparam int SAW = $clog2(3 * MAX_WIDTH);
  localparam int PAW = $clog2(8 * MAX_WIDTH);

  logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [CW-1:0]    in_col_q, out_col_q;
  logic [RW-1:0]    in_row_q, out_row_q;
  logic [1:0]       in_r3_q;
  logic             op_q;
  logic [7:0]       red_q, green_q, blue_q;
  logic [15:0]      cen_q;
  logic             peak_q;
  logic [8:0]       sum_q;
  logic [4:0]       cnt_q;
  logic [16:0]      rem_q;
  logic [19:0]      dvs_q;
  logic [7:0]       quo_q;
  logic             out_valid_q;
  logic [7:0]       gray_q;
  logic [9:0]       ox_q, oy_q;
  logic             fe_q;

  logic [CW-1:0] w;
  logic [RW-1:0] h;
  logic          cfg_wr, zero;
  logic [7:0]    mx, mn;

  logic signed [SW-1:0] ws, hs, rs, cs, cy, cx, ny, nx, oys, oxs, tyy, txx;
  logic signed [2:0]    dy, dx;
  logic [1:0]           slot_cy, slot_ny;
  logic                 ky, kx;

  logic [SAW-1:0] sat_wr_addr, sat_rd_addr;
  logic [PAW-1:0] pk_wr_addr, pk_rd_addr;
  logic [15:0]    sat_rd;
  logic           pk_rd;

  logic [RW:0] ry, oy3, hm1;
  logic [CW:0] rx, ox3, wm1;
  logic        ready;

  function automatic logic sat_ge(logic [15:0] a, logic [15:0] b);
    logic [7:0]  anum, bnum, aden, bden;
    logic [15:0] lhs, rhs;
    anum = a[15:8] - a[7:0];
    bnum = b[15:8] - b[7:0];
    aden = (a[15:8] == 8'd0) ? 8'd1 : a[15:8];
    bden = (b[15:8] == 8'd0) ? 8'd1 : b[15:8];
    lhs  = anum * bden;
    rhs  = bnum * aden;
    return lhs >= rhs;
  endfunction

  // frame size as used, out of range values clamped
  always_comb begin
    if (cfg_w_q == '0) begin
      w = CW'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h = RW'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      h = RW'(MAX_HEIGHT);
    end else begin
      h = RW'(cfg_h_q);
    end
  end

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? APB_DW'(cfg_h_q) : APB_DW'(cfg_w_q);

  assign zero = (32'(in_col_q) >= 32'(w)) || (32'(in_row_q) > 32'(h)) ||
                (32'(out_col_q) >= 32'(w)) || (32'(out_row_q) > 32'(h)) ||
                (!op_q && (32'(in_row_q) >= 32'(h)));

  always_comb begin
    mx = red_q;
    mn = red_q;
    if (green_q > mx) mx = green_q;
    if (blue_q > mx)  mx = blue_q;
    if (green_q < mn) mn = green_q;
    if (blue_q < mn)  mn = blue_q;
  end

  // peak candidate and 3x3 neighbour addressing
  always_comb begin
    ws      = $signed(SW'(w));
    hs      = $signed(SW'(h));
    rs      = $signed(SW'(in_row_q));
    cs      = $signed(SW'(in_col_q));
    ky      = cmd_i.cand[1];
    kx      = cmd_i.cand[0];
    cy      = ky ? rs : rs - $signed(SW'(1));
    cx      = kx ? cs : cs - $signed(SW'(1));
    dy      = nb_dy(cmd_i.nb);
    dx      = nb_dx(cmd_i.nb);
    ny      = cy + {{(SW-3){dy[2]}}, dy};
    nx      = cx + {{(SW-3){dx[2]}}, dx};
    slot_cy = ky ? in_r3_q : mod3_dec(in_r3_q);
    if (dy < 0) begin
      slot_ny = mod3_dec(slot_cy);
    end else if (dy > 0) begin
      slot_ny = mod3_inc(slot_cy);
    end else begin
      slot_ny = slot_cy;
    end
    sat_wr_addr = SAW'(32'(in_r3_q) * MAX_WIDTH) + SAW'(in_col_q);
    sat_rd_addr = SAW'(32'(slot_ny) * MAX_WIDTH) + SAW'($unsigned(nx));
    pk_wr_addr  = PAW'(32'(cy[2:0]) * MAX_WIDTH) + PAW'($unsigned(cx));
  end

  // output window taps
  always_comb begin
    oys = $signed(SW'(out_row_q));
    oxs = $signed(SW'(out_col_q));
    tyy = oys + $signed(SW'(cmd_i.tap_y)) - $signed(SW'(2));
    txx = oxs + $signed(SW'(cmd_i.tap_x)) - $signed(SW'(2));
    pk_rd_addr = PAW'(32'(tyy[2:0]) * MAX_WIDTH) + PAW'($unsigned(txx));
  end

  // result window complete
  always_comb begin
    hm1 = (RW+1)'(h) - (RW+1)'(1);
    wm1 = (CW+1)'(w) - (CW+1)'(1);
    oy3 = (RW+1)'(out_row_q) + (RW+1)'(3);
    ox3 = (CW+1)'(out_col_q) + (CW+1)'(3);
    ry  = (oy3 < hm1) ? oy3 : hm1;
    rx  = (ox3 < wm1) ? ox3 : wm1;
    if (out_row_q >= h) begin
      ready = 1'b0;
    end else if (in_row_q >= h) begin
      ready = 1'b1;
    end else begin
      ready = ((RW+1)'(in_row_q) > ry) ||
              (((RW+1)'(in_row_q) == ry) && ((CW+1)'(in_col_q) > rx));
    end
  end

  always_comb begin
    sts_o.pixel     = !op_q;
    sts_o.cand_ok   = !cy[SW-1] && !cx[SW-1] && (!ky || (rs == hs - $signed(SW'(1)))) &&
                      (!kx || (cs == ws - $signed(SW'(1))));
    sts_o.nb_in     = !ny[SW-1] && (ny < hs) && !nx[SW-1] && (nx < ws);
    sts_o.tap_in    = !tyy[SW-1] && (tyy < hs) && !txx[SW-1] && (txx < ws);
    sts_o.out_ready = ready;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  spgm_ram #(.WIDTH(16), .DEPTH(3 * MAX_WIDTH)) u_sat_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.sat_wr),
    .wr_addr_i (sat_wr_addr),
    .wr_data_i ({mx, mn}),
    .rd_en_i   (cmd_i.nb_rd),
    .rd_addr_i (sat_rd_addr),
    .rd_data_o (sat_rd)
  );

  spgm_ram #(.WIDTH(1), .DEPTH(8 * MAX_WIDTH)) u_peak_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.pk_wr),
    .wr_addr_i (pk_wr_addr),
    .wr_data_i (peak_q),
    .rd_en_i   (cmd_i.tap_rd),
    .rd_addr_i (pk_rd_addr),
    .rd_data_o (pk_rd)
  );

  // configuration and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= FRAME_WIDTH_RST;
      cfg_h_q   <= FRAME_HEIGHT_RST;
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_r3_q   <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_FRAME_WIDTH:  cfg_w_q <= pwdata[CFG_W-1:0];
          REG_FRAME_HEIGHT: cfg_h_q <= pwdata[CFG_W-1:0];
          default:          cfg_w_q <= cfg_w_q;
        endcase
        in_col_q  <= '0;
        in_row_q  <= '0;
        in_r3_q   <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else if (cmd_i.prep && zero) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        in_r3_q   <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        if (cmd_i.advance) begin
          if (in_col_q == w - CW'(1)) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + RW'(1);
            in_r3_q  <= mod3_inc(in_r3_q);
          end else begin
            in_col_q <= in_col_q + CW'(1);
          end
        end
        if (cmd_i.emit) begin
          if (out_col_q == w - CW'(1)) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + RW'(1);
          end else begin
            out_col_q <= out_col_q + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= opcode_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      sum_q   <= '0;
      cnt_q   <= '0;
    end
    if (cmd_i.nb_rd && (cmd_i.nb == NB_CENTRE)) begin
      peak_q <= 1'b1;
    end
    if (cmd_i.nb_cmp) begin
      if (cmd_i.nb == NB_CENTRE) begin
        cen_q <= sat_rd;
      end else if (sat_ge(sat_rd, cen_q)) begin
        peak_q <= 1'b0;
      end
    end
    if (cmd_i.tap_acc && pk_rd) begin
      sum_q <= sum_q + 9'(gauss_w(cmd_i.tap_y, cmd_i.tap_x));
      cnt_q <= cnt_q + 5'd1;
    end
    if (cmd_i.div_init) begin
      rem_q <= 17'(32'(sum_q) * 255);
      dvs_q <= 20'(32'(cnt_q) * 273 * 128);
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (20'(rem_q) >= dvs_q) begin
        rem_q <= rem_q - 17'(dvs_q);
        quo_q <= {quo_q[6:0], 1'b1};
      end else begin
        quo_q <= {quo_q[6:0], 1'b0};
      end
      dvs_q <= dvs_q >> 1;
    end
    if (cmd_i.emit) begin
      gray_q <= (cnt_q == '0) ? 8'd0 : quo_q;
      ox_q   <= 10'(out_col_q);
      oy_q   <= 10'(out_row_q);
      fe_q   <= (out_row_q == h - RW'(1)) && (out_col_q == w - CW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign gray_o      = gray_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign frame_end_o = fe_q;

endmodule

FILE: design/saturation_peak_gaussian_marker_unit.sv
// top level of the saturation peak gaussian marker
// One transaction at a time, and the input stays stalled until it is done. A
// pixel transaction runs a 3x3 peak test for each candidate that it
// completes, with one saturation read for each in-frame neighbour, centre
// included. An interior pixel completes one test and the last column and row up
// to four. All reads share the single read port of the saturation line store.
// A transaction that releases a result then scans the 5x5 window of the peak
// line store, reading each in-frame bit, and runs the 8-step divider and loads
// the output register, waiting while a stalled earlier result holds the output
// register. The line stores need no clearing pass after reset.
module saturation_peak_gaussian_marker_unit import spgm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        gray_o,
  output logic [9:0]        out_x_o,
  output logic [9:0]        out_y_o,
  output logic              frame_end_o
);

  spgm_cmd_t cmd;
  spgm_sts_t sts;

  spgm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spgm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .opcode_i    (opcode_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .gray_o      (gray_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .frame_end_o (frame_end_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: design/spgm_checker.sv
// port level checks of the saturation peak marker and their binding
module spgm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] gray_o,
  input logic [9:0] out_x_o
);

  // a stalled result transaction stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(gray_o) && $stable(out_x_o))
    else $error("result changed while stalled");

  // an accepted transaction keeps the input stalled while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the transaction finished");

endmodule

bind saturation_peak_gaussian_marker_unit spgm_checker u_spgm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .gray_o      (gray_o),
  .out_x_o     (out_x_o)
);

FILE: tb/tb_top.sv
// self-checking testbench for the saturation peak gaussian marker unit
`timescale 1ns / 100ps

module tb_top;
  import spgm_pkg::*;

  typedef struct packed {
    logic [7:0] gray;
    logic [9:0] col;
    logic [9:0] row;
    logic       frame_end;
  } marker_px_t;

  localparam int LINE_MAX = DEF_MAX_WIDTH;
  localparam int ROW_MAX  = DEF_MAX_HEIGHT;

  class gray_scoreboard;
    bit [15:0]   sat_line [3][LINE_MAX];
    bit          peak_line [8][LINE_MAX];
    int unsigned in_col, in_row, out_col, out_row;
    int unsigned cfg_w, cfg_h;
    marker_px_t  gray_expected [$];
    int          mismatches;
    int          checked;

    function new();
      cfg_w = 64;
      cfg_h = 64;
    endfunction

    function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function void set_reg(logic idx, int unsigned v);
      if (idx == REG_FRAME_WIDTH) begin
        cfg_w = v & 'h7ff;
      end else begin
        cfg_h = v & 'h7ff;
      end
      restart();
    endfunction

    function int unsigned eff_size(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function bit sat_ge(bit [15:0] a, bit [15:0] b);
      int unsigned amax, bmax, anum, bnum, aden, bden;
      amax = a[15:8];
      bmax = b[15:8];
      anum = amax - a[7:0];
      bnum = bmax - b[7:0];
      aden = amax ? amax : 1;
      bden = bmax ? bmax : 1;
      return anum * bden >= bnum * aden;
    endfunction

    function bit peak_at(int y, int x, int w, int h);
      bit [15:0] centre;
      int ny, nx;
      centre = sat_line[y % 3][x];
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          ny = y + dy;
          nx = x + dx;
          if (dy == 0 && dx == 0) continue;
          if (ny < 0 || ny >= h || nx < 0 || nx >= w) continue;
          if (sat_ge(sat_line[ny % 3][nx], centre)) return 0;
        end
      end
      return 1;
    endfunction

    function bit out_ready();
      int unsigned w, h, ry, rx;
      w = eff_size(cfg_w, LINE_MAX);
      h = eff_size(cfg_h, ROW_MAX);
      if (out_row >= h) return 0;
      if (in_row >= h) return 1;
      ry = (out_row + 3 < h - 1) ? out_row + 3 : h - 1;
      rx = (out_col + 3 < w - 1) ? out_col + 3 : w - 1;
      return in_row > ry || (in_row == ry && in_col > rx);
    endfunction

    function marker_px_t emit_px(int w, int h);
      marker_px_t px;
      int unsigned sum, n;
      int y, x;
      sum = 0;
      n = 0;
      for (int dy = -2; dy <= 2; dy++) begin
        for (int dx = -2; dx <= 2; dx++) begin
          y = int'(out_row) + dy;
          x = int'(out_col) + dx;
          if (y < 0 || y >= h || x < 0 || x >= w) continue;
          if (peak_line[y % 8][x]) begin
            sum += GAUSS_W[dy + 2][dx + 2];
            n++;
          end
        end
      end
      px.gray = n ? 8'((255 * sum) / (273 * n)) : 8'd0;
      px.col = 10'(out_col);
      px.row = 10'(out_row);
      px.frame_end = (out_row == h - 1 && out_col == w - 1);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      return px;
    endfunction

    function void take_item(logic op, logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
      int w, h, r, c;
      logic [7:0] mx, mn;
      w = eff_size(cfg_w, LINE_MAX);
      h = eff_size(cfg_h, ROW_MAX);
      if (in_col >= w || in_row > h || out_col >= w || out_row > h) restart();
      if (op == 1'b0) begin
        if (in_row >= h) restart();
        mx = r8;
        mn = r8;
        if (g8 > mx) mx = g8;
        if (b8 > mx) mx = b8;
        if (g8 < mn) mn = g8;
        if (b8 < mn) mn = b8;
        sat_line[in_row % 3][in_col] = {mx, mn};
        r = in_row;
        c = in_col;
        for (int y = r - 1; y <= r; y++) begin
          if (y < 0 || (y == r && r != h - 1)) continue;
          for (int x = c - 1; x <= c; x++) begin
            if (x < 0 || (x == c && c != w - 1)) continue;
            peak_line[y % 8][x] = peak_at(y, x, w, h);
          end
        end
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end
      if (out_ready()) gray_expected.insert(gray_expected.size(), emit_px(w, h));
    endfunction

    function void check_gray(marker_px_t got);
      marker_px_t want;
      if (gray_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: gray %0d x %0d y %0d end %0d",
                   got.gray, got.col, got.row, got.frame_end);
        return;
      end
      want = gray_expected.pop_front();
      checked++;
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected gray %0d x %0d y %0d end %0d, got %0d %0d %0d %0d",
                   want.gray, want.col, want.row, want.frame_end,
                   got.gray, got.col, got.row, got.frame_end);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              opcode_i = 1'b0;
  logic [7:0]        red_i = '0;
  logic [7:0]        green_i = '0;
  logic [7:0]        blue_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        gray_o;
  logic [9:0]        out_x_o;
  logic [9:0]        out_y_o;
  logic              frame_end_o;

  gray_scoreboard sb = new();
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  item_count = 0;
  int  frame_count = 0;

  saturation_peak_gaussian_marker_unit i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .opcode_i, .red_i, .green_i, .blue_i,
    .out_valid_o, .out_stall_i, .gray_o, .out_x_o, .out_y_o, .frame_end_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver stalls, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_gray('{gray_o, out_x_o, out_y_o, frame_end_o});
  end

  task automatic send_item(logic op, logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    red_i <= r8;
    green_i <= g8;
    blue_i <= b8;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_item(op, r8, g8, b8);
    item_count++;
  endtask

  task automatic send_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    send_item(1'b0, r8, g8, b8);
  endtask

  task automatic send_drain();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic flush_results();
    while (sb.out_ready()) send_drain();
    send_drain();
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.gray_expected.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [APB_DW-1:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic random_pixel(int style, logic [7:0] flat);
    logic [7:0] r8, g8, b8;
    r8 = 8'($urandom);
    g8 = 8'($urandom);
    b8 = 8'($urandom);
    case (style)
      0: send_pixel(r8, g8, b8);
      1: send_pixel(flat, flat, flat);
      2: if ($urandom_range(0, 5) == 0) send_pixel(r8, 8'd0, b8);
         else send_pixel(flat, flat, 8'(flat - $urandom_range(0, 2)));
      default: send_pixel(r8 & 8'hc0, g8 | 8'h3f, b8 & 8'h81);
    endcase
  endtask

  task automatic run_frame(int unsigned w, int unsigned h, bit partial);
    int unsigned total, cnt;
    int style;
    logic [7:0] flat;
    total = sb.eff_size(w, LINE_MAX) * sb.eff_size(h, ROW_MAX);
    cnt = partial ? $urandom_range(1, total) : total;
    style = $urandom_range(0, 3);
    flat = 8'($urandom);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 9) == 0) send_drain();
      random_pixel(style, flat);
    end
    flush_results();
    frame_count++;
  endtask

  initial begin
    #5_000_000;
    $display("saturation_peak_gaussian_marker_unit regression: fail");
    $finish;
  end

  initial begin
    int unsigned w, h;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain with nothing pending
    send_item(1'b1, 8'hff, 8'hff, 8'hff);
    wait_idle();
    set_frame(3, 2);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd1);
    flush_results();
    wait_idle();
    // zero sizes act as one
    set_frame(0, 0);
    send_pixel(8'd200, 8'd10, 8'd0);
    send_pixel(8'd7, 8'd7, 8'd7);
    flush_results();
    wait_idle();
    // new frame over undrained results
    set_frame(2, 2);
    repeat (8) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    flush_results();
    wait_idle();
    // oversized width, then oversized height
    set_frame(2047, 1);
    repeat (300) random_pixel(0, 8'd0);
    flush_results();
    wait_idle();
    set_frame(0, 2047);
    repeat (150) random_pixel(0, 8'd0);
    flush_results();
    wait_idle();

    while (item_count < 1000) begin
      if (item_count > 850) idle_on = 1'b0;
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      set_frame(w, h);
      if (frame_count >= 6) hold_req = 1'b1;
      run_frame(w, h, $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) run_frame(w, h, 0);
      wait_idle();
    end

    wait_idle();
    $display("covered %0d transactions over %0d frames, %0d results checked",
             item_count, frame_count, sb.checked);
    if (sb.mismatches == 0 && sb.gray_expected.size() == 0) begin
      $display("saturation_peak_gaussian_marker_unit regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.gray_expected.size());
      $display("saturation_peak_gaussian_marker_unit regression: fail");
    end
    $finish;
  end

endmodule
